FILE: hw/rtl/nfbia_pkg.sv
package nfbia_pkg;

  // Default number of identifiers and fixed field widths
  localparam int NumIdsDefault = 64;
  localparam int ID_W          = 7;
  localparam int STATUS_W      = 2;

  // Request codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUT_OF_IDS = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_FREE   = 2'd2;

  typedef struct packed {
    logic            op;
    logic [ID_W-1:0] free_id;
  } nfbia_in_t;

  typedef struct packed {
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;
  } nfbia_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the request
    logic eval;    // run the searches and the free check
    logic commit;  // update bitmap and write the result register
  } nfbia_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_room;  // result register can take a new result this cycle
  } nfbia_sts_t;

endpackage

FILE: hw/rtl/nfbia_ctrl.sv
module nfbia_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  nfbia_pkg::nfbia_sts_t sts,
  output nfbia_pkg::nfbia_cmd_t cmd
);
  import nfbia_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.eval   = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        // hold until the result register frees up
        if (sts.out_room) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/nfbia_dp.sv
module nfbia_dp #(
  parameter int NUM_IDS = nfbia_pkg::NumIdsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nfbia_pkg::nfbia_in_t  in_data,
  input  nfbia_pkg::nfbia_cmd_t cmd,
  output nfbia_pkg::nfbia_sts_t sts,
  output logic                  out_valid,
  input  logic                  out_stall,
  output nfbia_pkg::nfbia_out_t out_data
);
  import nfbia_pkg::*;

  localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int EXT_N = 1 << IDX_W;

  nfbia_in_t          req_r;
  logic [NUM_IDS-1:0] marks_r;
  logic [IDX_W-1:0]   last_r;

  logic               hi_any_r, lo_any_r, free_ok_r;
  logic [IDX_W-1:0]   hi_idx_r, lo_idx_r, fidx_r;
  logic               hi_any_nxt, lo_any_nxt, free_ok_nxt;
  logic [IDX_W-1:0]   hi_idx_nxt, lo_idx_nxt, fidx_nxt;

  logic               out_valid_r;
  nfbia_out_t         out_r;

  logic [NUM_IDS-1:0] free_v;
  logic [NUM_IDS-1:0] hi_v;
  logic [EXT_N-1:0]   marks_ext;
  logic               fid_in_range;
  logic [ID_W-1:0]    fid_m1;
  logic               pick_any;
  logic [IDX_W-1:0]   pick_idx;

  assign sts.out_room = !out_valid_r || !out_stall;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  // Two priority searches: free entries above the last grant, and all free entries
  always_comb begin
    free_v = ~marks_r;
    for (int i = 0; i < NUM_IDS; i++) begin
      hi_v[i] = free_v[i] && (IDX_W'(i) > last_r);
    end
    hi_any_nxt = |hi_v;
    lo_any_nxt = |free_v;
    hi_idx_nxt = '0;
    lo_idx_nxt = '0;
    for (int i = NUM_IDS - 1; i >= 0; i--) begin
      if (hi_v[i]) begin
        hi_idx_nxt = IDX_W'(i);
      end
      if (free_v[i]) begin
        lo_idx_nxt = IDX_W'(i);
      end
    end
  end

  // Free check: id in range and currently marked
  always_comb begin
    marks_ext    = EXT_N'(marks_r);
    fid_in_range = (req_r.free_id != '0) && (req_r.free_id <= ID_W'(NUM_IDS));
    fid_m1       = req_r.free_id - ID_W'(1);
    fidx_nxt     = fid_m1[IDX_W-1:0];
    free_ok_nxt  = fid_in_range && marks_ext[fidx_nxt];
  end

  assign pick_any = hi_any_r || lo_any_r;
  assign pick_idx = hi_any_r ? hi_idx_r : lo_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.eval) begin
      hi_any_r  <= hi_any_nxt;
      lo_any_r  <= lo_any_nxt;
      hi_idx_r  <= hi_idx_nxt;
      lo_idx_r  <= lo_idx_nxt;
      free_ok_r <= free_ok_nxt;
      fidx_r    <= fidx_nxt;
    end
    if (cmd.commit) begin
      out_r.granted_id <= '0;
      out_r.status     <= STATUS_OK;
      if (req_r.op == OP_ALLOC) begin
        if (pick_any) begin
          out_r.granted_id <= ID_W'(pick_idx) + ID_W'(1);
        end else begin
          out_r.status <= STATUS_OUT_OF_IDS;
        end
      end else if (!free_ok_r) begin
        out_r.status <= STATUS_BAD_FREE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marks_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
        if (req_r.op == OP_ALLOC) begin
          if (pick_any) begin
            marks_r[pick_idx] <= 1'b1;
            last_r            <= pick_idx;
          end
        end else if (free_ok_r) begin
          marks_r[fidx_r] <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

FILE: hw/rtl/next_fit_bitmap_id_allocator.sv
// Next-fit identifier allocator over a bitmap of NUM_IDS in-use marks.
// Input channel (in_valid / in_stall / in_data): one request per transfer.
//   op = allocate: scan circularly from the entry after the last grant,
//   mark the first free entry and return its index plus one (zero is
//   reserved). With every entry taken, status reports out of ids.
//   op = free: clear the mark of free_id minus one; zero, out-of-range or
//   unused ids report a bad free and change nothing.
// Result channel (out_valid / out_stall / out_data): one transfer per request.
// Sequence: a request is captured in the idle state, evaluated in the
//   evaluate state (two priority searches over the bitmap), and its
//   result is registered in the update state once the register has room.
//   The controller handles one request at a time, taking no new one until
//   it commits, and waits while the result register holds an untaken result.
// Reset clears the bitmap and the last-granted index, so the first grant
//   after reset is id 2. A pending result in the output register is held
//   while out_stall is high; a new request is still accepted meanwhile.
module next_fit_bitmap_id_allocator #(
  parameter int NUM_IDS = nfbia_pkg::NumIdsDefault
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  nfbia_pkg::nfbia_in_t  in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output nfbia_pkg::nfbia_out_t out_data
);
  import nfbia_pkg::*;

  nfbia_cmd_t cmd;
  nfbia_sts_t sts;

  // Sequencer: idle, evaluate, update
  nfbia_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Bitmap, search registers and result register
  nfbia_dp #(
    .NUM_IDS (NUM_IDS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
